[sv/csq_pkg.sv]
package csq_pkg;

    // width of one stored word
    localparam int VALUE_W = 64;

    // command codes carried in tuser; the two spare codes act as read only
    typedef enum logic [2:0] {
        FUNC_START   = 3'd0,
        FUNC_ADVANCE = 3'd1,
        FUNC_INSERT  = 3'd2,
        FUNC_ATTACH  = 3'd3,
        FUNC_REMOVE  = 3'd4,
        FUNC_READ    = 3'd5,
        FUNC_SPARE6  = 3'd6,
        FUNC_SPARE7  = 3'd7
    } t_func;

    // per-command move broadcast to every cell of the chain
    typedef struct packed {
        logic load;        // cell at the position takes the new word
        logic shift_up;    // cells above the position take their lower neighbor
        logic shift_down;  // cells at or above the position take their upper neighbor
    } t_cell_ctl;

endpackage

[sv/csq_cell.sv]
module csq_cell
    import csq_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [IW-1:0]      i_pos,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [VALUE_W-1:0] i_lower,
    input  logic [VALUE_W-1:0] i_upper,
    output logic [VALUE_W-1:0] o_value
);

    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [VALUE_W-1:0] r_word;
    logic [VALUE_W-1:0] n_word;
    logic               w_at;
    logic               w_above;

    // where this cell sits relative to the edit position
    assign w_at    = (i_pos == MY_POS);
    assign w_above = (MY_POS > i_pos);

    // pick the word this cell holds after the command
    always_comb begin
        n_word = r_word;
        if (i_ctl.load && w_at) begin
            n_word = i_value;
        end else if (i_ctl.shift_up && w_above) begin
            n_word = i_lower;
        end else if (i_ctl.shift_down && (w_at || w_above)) begin
            n_word = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_value = r_word;

endmodule

[sv/cursor_sequence_store_unit.sv]
// ordered word store with a cursor, built as a chain of one-word cells
// result beat: an accepted command sets a pending flag, then the output register
//   takes the word at the cursor once it is free; no new command is taken while a
//   result is pending, and the read (a select across all cells) follows the cell move
// reset: synchronous active low; clears count, cursor and handshake state,
//   stored words stay as they are and are never read before written
module cursor_sequence_store_unit
    import csq_pkg::*;
#(
    parameter int CAPACITY = 32,
    localparam int IW    = $clog2(CAPACITY),
    localparam int CW    = $clog2(CAPACITY + 1),
    localparam int OUT_W = ((VALUE_W + CW + 2 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,  // [63:0] entry_value
    input  logic [2:0]         i_s_tuser,  // [2:0] func
    // master side
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata   // [63:0] cur_value, has_item, item_count, error
);

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_cur;
    logic [CW-1:0]      n_cnt;
    logic [CW-1:0]      n_cur;
    logic               r_pend;
    logic               r_pend_err;
    logic               n_err;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_has;
    logic [CW-1:0]      r_out_cnt;
    logic               r_out_err;

    logic               w_accept;
    logic               w_has;
    logic               w_full;
    logic               w_out_free;
    t_func              w_func;
    t_cell_ctl          w_ctl;
    t_cell_ctl          w_ctl_gated;
    logic [IW-1:0]      w_pos;
    logic [VALUE_W-1:0] w_val [CAPACITY];

    assign w_func     = t_func'(i_s_tuser);
    assign w_has      = (r_cur < r_cnt);
    assign w_full     = (r_cnt == CW'(CAPACITY));
    assign o_s_tready = !r_pend;
    assign w_accept   = i_s_tvalid && !r_pend;
    assign w_out_free = !r_out_valid || i_m_tready;

    // command decode: new cursor, count and the move the cells make
    always_comb begin
        n_cur = r_cur;
        n_cnt = r_cnt;
        n_err = 1'b0;
        w_ctl = '0;
        w_pos = r_cur[IW-1:0];
        unique case (w_func)
            FUNC_START: begin
                n_cur = '0;
            end
            FUNC_ADVANCE: begin
                if (w_has) begin
                    n_cur = r_cur + CW'(1);
                end else begin
                    n_err = 1'b1;
                end
            end
            FUNC_INSERT: begin
                if (w_full) begin
                    n_err = 1'b1;
                end else begin
                    n_cur          = w_has ? r_cur : '0;
                    w_pos          = n_cur[IW-1:0];
                    w_ctl.load     = 1'b1;
                    w_ctl.shift_up = 1'b1;
                    n_cnt          = r_cnt + CW'(1);
                end
            end
            FUNC_ATTACH: begin
                if (w_full) begin
                    n_err = 1'b1;
                end else begin
                    n_cur          = w_has ? (r_cur + CW'(1)) : r_cnt;
                    w_pos          = n_cur[IW-1:0];
                    w_ctl.load     = 1'b1;
                    w_ctl.shift_up = 1'b1;
                    n_cnt          = r_cnt + CW'(1);
                end
            end
            FUNC_REMOVE: begin
                if (w_has) begin
                    w_ctl.shift_down = 1'b1;
                    n_cnt            = r_cnt - CW'(1);
                end else begin
                    n_err = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // cells only move on an accepted beat
    assign w_ctl_gated = w_accept ? w_ctl : '0;

    // chain of cells, each wired to its neighbors; the first sees zero below, the last itself above
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_W-1:0] w_lower;
        logic [VALUE_W-1:0] w_upper;
        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_inner_lo
            assign w_lower = w_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = w_val[k];
        end else begin : g_inner_hi
            assign w_upper = w_val[k+1];
        end
        csq_cell #(
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl_gated),
            .i_pos   (w_pos),
            .i_value (i_s_tdata),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_value (w_val[k])
        );
    end

    // cursor, count and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_cur      <= '0;
            r_pend     <= 1'b0;
            r_pend_err <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt      <= n_cnt;
                r_cur      <= n_cur;
                r_pend     <= 1'b1;
                r_pend_err <= n_err;
            end else if (r_pend && w_out_free) begin
                r_pend <= 1'b0;
            end
        end
    end

    // output register: select the word at the cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_out_free) begin
            r_out_value <= w_has ? w_val[r_cur[IW-1:0]] : '0;
            r_out_has   <= w_has;
            r_out_cnt   <= r_cnt;
            r_out_err   <= r_pend_err;
        end
    end

    // pack the result beat
    always_comb begin
        o_m_tdata                  = '0;
        o_m_tdata[VALUE_W-1:0]     = r_out_value;
        o_m_tdata[VALUE_W]         = r_out_has;
        o_m_tdata[VALUE_W+1 +: CW] = r_out_cnt;
        o_m_tdata[VALUE_W+1+CW]    = r_out_err;
    end

    assign o_m_tvalid = r_out_valid;

endmodule
